### sv/mmx_pkg.sv
package mmx_pkg;

  localparam int WORD_BITS = 64;
  localparam int OP_W      = 63;
  localparam int EXP_W     = 64;
  localparam int KB_W      = 7;
  localparam int IDX_W     = $clog2(EXP_W);

  // Commands
  localparam logic [1:0] CMD_MUL  = 2'd0;
  localparam logic [1:0] CMD_TO   = 2'd1;
  localparam logic [1:0] CMD_FROM = 2'd2;
  localparam logic [1:0] CMD_POW  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_MODULUS = 2'd0;
  localparam logic [1:0] CFG_RBITS   = 2'd1;
  localparam logic [1:0] CFG_NINV    = 2'd2;
  localparam logic [1:0] CFG_R2      = 2'd3;

  // Product operand selects
  localparam logic       XSEL_A    = 1'b0;
  localparam logic       XSEL_RES  = 1'b1;
  localparam logic [2:0] YSEL_B    = 3'd0;
  localparam logic [2:0] YSEL_R2   = 3'd1;
  localparam logic [2:0] YSEL_ONE  = 3'd2;
  localparam logic [2:0] YSEL_RES  = 3'd3;
  localparam logic [2:0] YSEL_BASE = 3'd4;

  typedef struct packed {
    logic       load;      // capture operands of an accepted beat
    logic       mm_start;  // launch one Montgomery product
    logic       xsel;
    logic [2:0] ysel;
    logic       base_we;   // keep product result as power base
    logic       out_we;    // load result register
    logic       out_one;   // result is the constant one
  } mmx_cmd_t;

  typedef struct packed {
    logic mm_done;
  } mmx_stat_t;

endpackage

### sv/mmx_mont.sv
// Iterative Montgomery product: three 64x64 products, each as four 32x32
// partial products on one shared multiplier, then shift and final subtract.
module mmx_mont import mmx_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [OP_W-1:0]   x,
  input  logic [OP_W-1:0]   y,
  input  logic [OP_W-1:0]   modulus,
  input  logic [WORD_BITS-1:0] ninv,
  input  logic [KB_W-1:0]   k,
  output logic              done,
  output logic [OP_W-1:0]   res
);

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_T     = 3'd1;
  localparam logic [2:0] PH_M     = 3'd2;
  localparam logic [2:0] PH_N     = 3'd3;
  localparam logic [2:0] PH_SHIFT = 3'd4;
  localparam logic [2:0] PH_SUB   = 3'd5;

  localparam int HW = WORD_BITS / 2;
  localparam int DW = 2 * WORD_BITS;

  logic [2:0]           ph_r, ph_nxt;
  logic [1:0]           step_r, step_nxt;
  logic                 done_r, done_nxt;
  logic [WORD_BITS-1:0] ma_r, ma_nxt, mb_r, mb_nxt;
  logic [DW-1:0]        acc_r, acc_nxt, t_r, t_nxt;
  logic [WORD_BITS-1:0] ulo_r, ulo_nxt;
  logic                 hinz_r, hinz_nxt;
  logic [OP_W-1:0]      res_r, res_nxt;

  logic [HW-1:0]        a_part, b_part;
  logic [WORD_BITS-1:0] pp;
  logic [DW-1:0]        pp_sh, acc_sum, s_sh;
  logic [WORD_BITS-1:0] mask, modx, diff;

  assign a_part  = step_r[0] ? ma_r[WORD_BITS-1:HW] : ma_r[HW-1:0];
  assign b_part  = step_r[1] ? mb_r[WORD_BITS-1:HW] : mb_r[HW-1:0];
  assign pp      = a_part * b_part;
  assign mask    = ~({WORD_BITS{1'b1}} << k);
  assign modx    = {1'b0, modulus};
  assign s_sh    = acc_r >> k;
  assign diff    = ulo_r - modx;

  always_comb begin
    case (step_r)
      2'd0:    pp_sh = {{WORD_BITS{1'b0}}, pp};
      2'd3:    pp_sh = {pp, {WORD_BITS{1'b0}}};
      default: pp_sh = {{HW{1'b0}}, pp, {HW{1'b0}}};
    endcase
  end

  assign acc_sum = acc_r + pp_sh;

  always_comb begin
    ph_nxt   = ph_r;
    step_nxt = step_r;
    done_nxt = 1'b0;
    ma_nxt   = ma_r;
    mb_nxt   = mb_r;
    acc_nxt  = acc_r;
    t_nxt    = t_r;
    ulo_nxt  = ulo_r;
    hinz_nxt = hinz_r;
    res_nxt  = res_r;
    unique case (ph_r)
      PH_IDLE: begin
        if (start) begin
          ma_nxt   = {1'b0, x};
          mb_nxt   = {1'b0, y};
          acc_nxt  = '0;
          step_nxt = 2'd0;
          ph_nxt   = PH_T;
        end
      end
      PH_T, PH_M, PH_N: begin
        acc_nxt  = acc_sum;
        step_nxt = step_r + 2'd1;
        if (step_r == 2'd3) begin
          if (ph_r == PH_T) begin
            // t done: next m = (t mod R) * n' mod R
            t_nxt   = acc_sum;
            ma_nxt  = acc_sum[WORD_BITS-1:0] & mask;
            mb_nxt  = ninv & mask;
            acc_nxt = '0;
            ph_nxt  = PH_M;
          end else if (ph_r == PH_M) begin
            // m*n is accumulated straight onto t
            ma_nxt  = acc_sum[WORD_BITS-1:0] & mask;
            mb_nxt  = modx;
            acc_nxt = t_r;
            ph_nxt  = PH_N;
          end else begin
            ph_nxt  = PH_SHIFT;
          end
        end
      end
      PH_SHIFT: begin
        ulo_nxt  = s_sh[WORD_BITS-1:0];
        hinz_nxt = |s_sh[DW-1:WORD_BITS];
        ph_nxt   = PH_SUB;
      end
      PH_SUB: begin
        res_nxt  = (hinz_r || (ulo_r >= modx)) ? diff[OP_W-1:0] : ulo_r[OP_W-1:0];
        done_nxt = 1'b1;
        ph_nxt   = PH_IDLE;
      end
      default: ph_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_IDLE;
      step_r <= 2'd0;
      done_r <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      step_r <= step_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ma_r   <= ma_nxt;
    mb_r   <= mb_nxt;
    acc_r  <= acc_nxt;
    t_r    <= t_nxt;
    ulo_r  <= ulo_nxt;
    hinz_r <= hinz_nxt;
    res_r  <= res_nxt;
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

### sv/mmx_dp.sv
// Datapath: configuration, operand and result registers around the product unit.
module mmx_dp import mmx_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mmx_cmd_t             cmd,
  output mmx_stat_t            stat,
  input  logic [OP_W-1:0]      in_operand_a,
  input  logic [OP_W-1:0]      in_operand_b,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [WORD_BITS-1:0] cfg_wdata,
  output logic [OP_W-1:0]      out_value
);

  logic [OP_W-1:0]      modulus_r, modulus_nxt;
  logic [KB_W-1:0]      rbits_r, rbits_nxt;
  logic [WORD_BITS-1:0] ninv_r, ninv_nxt;
  logic [OP_W-1:0]      r2_r, r2_nxt;
  logic [OP_W-1:0]      a_r, b_r, base_r, out_r;
  logic [OP_W-1:0]      mx, my, mres;
  logic [KB_W-1:0]      keff;
  logic                 mdone;

  localparam logic [KB_W-1:0] K_MIN = KB_W'(2);
  localparam logic [KB_W-1:0] K_MAX = KB_W'(WORD_BITS);
  localparam logic [OP_W-1:0] ONE   = OP_W'(1);

  always_comb begin
    modulus_nxt = modulus_r;
    rbits_nxt   = rbits_r;
    ninv_nxt    = ninv_r;
    r2_nxt      = r2_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODULUS: modulus_nxt = cfg_wdata[OP_W-1:0];
        CFG_RBITS:   rbits_nxt   = cfg_wdata[KB_W-1:0];
        CFG_NINV:    ninv_nxt    = cfg_wdata;
        CFG_R2:      r2_nxt      = cfg_wdata[OP_W-1:0];
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= ONE;
      rbits_r   <= K_MIN;
      ninv_r    <= WORD_BITS'(3);
      r2_r      <= '0;
    end else begin
      modulus_r <= modulus_nxt;
      rbits_r   <= rbits_nxt;
      ninv_r    <= ninv_nxt;
      r2_r      <= r2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r <= in_operand_a;
      b_r <= in_operand_b;
    end
    if (cmd.base_we) base_r <= mres;
    if (cmd.out_we)  out_r  <= cmd.out_one ? ONE : mres;
  end

  // R = 2^k, k held within 2..WORD_BITS
  assign keff = (rbits_r < K_MIN) ? K_MIN : ((rbits_r > K_MAX) ? K_MAX : rbits_r);

  assign mx = (cmd.xsel == XSEL_RES) ? mres : a_r;

  always_comb begin
    unique case (cmd.ysel)
      YSEL_B:    my = b_r;
      YSEL_R2:   my = r2_r;
      YSEL_ONE:  my = ONE;
      YSEL_RES:  my = mres;
      YSEL_BASE: my = base_r;
      default:   my = ONE;
    endcase
  end

  mmx_mont u_mont (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.mm_start),
    .x       (mx),
    .y       (my),
    .modulus (modulus_r),
    .ninv    (ninv_r),
    .k       (keff),
    .done    (mdone),
    .res     (mres)
  );

  assign stat.mm_done = mdone;
  assign out_value    = out_r;

endmodule

### sv/mmx_ctrl.sv
// Controller: command decode and square-and-multiply sequencing.
module mmx_ctrl import mmx_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [1:0]       in_cmd,
  input  logic [EXP_W-1:0] in_exponent,
  output logic             busy,
  output logic             out_valid,
  output mmx_cmd_t         cmd,
  input  mmx_stat_t        stat
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GO   = 3'd1;
  localparam logic [2:0] S_BASE = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_SQ   = 3'd4;
  localparam logic [2:0] S_ML   = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0]       state_r, state_nxt;
  logic [1:0]       cmd_r, cmd_nxt;
  logic [EXP_W-1:0] exp_r, exp_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             ov_r, ov_nxt;
  logic             ebit;

  assign ebit = exp_r[idx_r];

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    exp_nxt   = exp_r;
    idx_nxt   = idx_r;
    ov_nxt    = 1'b0;
    cmd       = '0;
    cmd.xsel  = XSEL_RES;
    cmd.ysel  = YSEL_RES;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          cmd_nxt   = in_cmd;
          exp_nxt   = in_exponent;
          state_nxt = S_GO;
        end
      end
      S_GO: begin
        cmd.xsel = XSEL_A;
        if (cmd_r == CMD_POW && exp_r == '0) begin
          cmd.out_we  = 1'b1;
          cmd.out_one = 1'b1;
          ov_nxt      = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          cmd.mm_start = 1'b1;
          unique case (cmd_r)
            CMD_MUL:  cmd.ysel = YSEL_B;
            CMD_FROM: cmd.ysel = YSEL_ONE;
            default:  cmd.ysel = YSEL_R2;
          endcase
          idx_nxt   = IDX_W'(EXP_W - 1);
          state_nxt = (cmd_r == CMD_POW) ? S_BASE : S_FIN;
        end
      end
      S_BASE: begin
        if (stat.mm_done) begin
          cmd.base_we = 1'b1;
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        // one exponent bit a cycle down to the leading one
        if (ebit) begin
          cmd.mm_start = 1'b1;
          if (idx_r == '0) begin
            cmd.ysel  = YSEL_ONE;
            state_nxt = S_FIN;
          end else begin
            idx_nxt   = idx_r - 1'b1;
            state_nxt = S_SQ;
          end
        end else begin
          idx_nxt = idx_r - 1'b1;
        end
      end
      S_SQ, S_ML: begin
        if (stat.mm_done) begin
          cmd.mm_start = 1'b1;
          if (state_r == S_SQ && ebit) begin
            cmd.ysel  = YSEL_BASE;
            state_nxt = S_ML;
          end else if (idx_r == '0) begin
            cmd.ysel  = YSEL_ONE;
            state_nxt = S_FIN;
          end else begin
            idx_nxt   = idx_r - 1'b1;
            state_nxt = S_SQ;
          end
        end
      end
      S_FIN: begin
        if (stat.mm_done) begin
          cmd.out_we = 1'b1;
          ov_nxt     = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    exp_r <= exp_nxt;
    idx_r <= idx_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = ov_r;

endmodule

### sv/montgomery_modular_exponentiation_unit.sv
// Montgomery arithmetic unit. A beat is taken when start is high and busy is
// low; busy then stays high until the result is loaded, and out_valid marks the
// result on out_value for exactly one cycle - it must be taken then, as the
// unit cannot be held off. One item is worked at a time. Each Montgomery
// product runs on a single shared 32x32 multiplier: three 64x64 products of
// four partial products each, then shift and final subtract. Commands 0 to 2
// take one product. A power with zero exponent answers straight from the
// decode state, with no product. Otherwise a power takes one product for the
// base, a scan of the exponent down to its leading one, then a square and,
// where the bit is set, a multiply for each bit below the leading one, and a
// final conversion product. The next start may come in the cycle out_valid
// shows. Configuration is written through cfg_we / cfg_index / cfg_wdata and
// must only change while busy is low and no result is pending.
module montgomery_modular_exponentiation_unit import mmx_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_cmd,
  input  logic [OP_W-1:0]      in_operand_a,
  input  logic [OP_W-1:0]      in_operand_b,
  input  logic [EXP_W-1:0]     in_exponent,
  output logic                 out_valid,
  output logic [OP_W-1:0]      out_value,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [WORD_BITS-1:0] cfg_wdata
);

  mmx_cmd_t  cmd;
  mmx_stat_t stat;

  // sequencer: decode, leading-bit scan, square-and-multiply order
  mmx_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_cmd      (in_cmd),
    .in_exponent (in_exponent),
    .busy        (busy),
    .out_valid   (out_valid),
    .cmd         (cmd),
    .stat        (stat)
  );

  // registers and the Montgomery product unit
  mmx_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .out_value    (out_value)
  );

endmodule

### sv/mmx_checker.sv
module mmx_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // a result only ever closes an item in progress
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result beat without an item in progress");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("busy still high with result shown");

  a_out_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result beat repeated");

endmodule

bind montgomery_modular_exponentiation_unit mmx_checker u_mmx_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);

### test/tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the Montgomery arithmetic unit.
module tb;
  import mmx_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000; // cycles with no beat in or out
  localparam int DRAIN_CYCLES   = 40;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [1:0]           in_cmd;
  logic [OP_W-1:0]      in_operand_a;
  logic [OP_W-1:0]      in_operand_b;
  logic [EXP_W-1:0]     in_exponent;
  logic                 out_valid;
  logic [OP_W-1:0]      out_value;
  logic                 cfg_we;
  logic [1:0]           cfg_index;
  logic [WORD_BITS-1:0] cfg_wdata;

  montgomery_modular_exponentiation_unit i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_cmd       (in_cmd),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .in_exponent  (in_exponent),
    .out_valid    (out_valid),
    .out_value    (out_value),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  // Shadow copy of the configuration registers
  logic [62:0] mod_n;
  logic [6:0]  rbits_k;
  logic [63:0] ninv;
  logic [62:0] r2_n;

  logic [62:0] value_q[$];   // expected result values, oldest first
  int          n_errors;
  int          n_sent;
  int          n_checked;
  int          idle_cycles;
  int          n_pow;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // One Montgomery product with the shadow configuration: t = x*y,
  // m = (t mod R)*n' mod R, u = (t + m*n) / R, one conditional subtract.
  function automatic logic [62:0] mont_product(logic [62:0] x, logic [62:0] y);
    int           k;
    logic [63:0]  mask;
    logic [127:0] t;
    logic [127:0] s;
    logic [127:0] u;
    logic [63:0]  m;
    logic [63:0]  diff;
    k = rbits_k;
    if (k < 2) k = 2;
    if (k > WORD_BITS) k = WORD_BITS;
    mask = (k >= 64) ? '1 : ((64'd1 << k) - 64'd1);
    t = {65'd0, x} * {65'd0, y};
    m = (t[63:0] & mask) * (ninv & mask);
    m = m & mask;
    s = t + ({64'd0, m} * {65'd0, mod_n});
    u = s >> k;
    diff = u[63:0];
    // t + m*n < 2^128 here, so the 128-bit sum never wraps
    if (u[127:64] != 64'd0 || u[63:0] >= {1'b0, mod_n})
      diff = u[63:0] - {1'b0, mod_n};
    return diff[62:0];
  endfunction

  // Left-to-right square-and-multiply, zero exponent answers one
  function automatic logic [62:0] mod_power(logic [62:0] a, logic [63:0] e);
    logic [62:0] base;
    logic [62:0] acc;
    int          top;
    if (e == 64'd0) return 63'd1;
    base = mont_product(a, r2_n);
    top = 63;
    while (!e[top]) top--;
    acc = base;
    for (int i = top - 1; i >= 0; i--) begin
      acc = mont_product(acc, acc);
      if (e[i]) acc = mont_product(acc, base);
    end
    return mont_product(acc, 63'd1);
  endfunction

  function automatic logic [62:0] predict_value(logic [1:0] cmd, logic [62:0] a,
                                                logic [62:0] b, logic [63:0] e);
    case (cmd)
      CMD_MUL:  return mont_product(a, b);
      CMD_TO:   return mont_product(a, r2_n);
      CMD_FROM: return mont_product(a, 63'd1);
      default:  return mod_power(a, e);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Checker and watchdog
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what);
    $display("ERROR at %0t: %s", $realtime, what);
    n_errors++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (value_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result value=%0h", out_value));
      end else begin
        logic [62:0] want;
        want = value_q.pop_front();
        if (out_value !== want)
          report_mismatch($sformatf("value got %0h want %0h", out_value, want));
        n_checked++;
      end
    end
  end

  // idle counter: cleared by any beat in either direction
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL montgomery_modular_exponentiation_unit");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Mostly short gaps, now and then a long one
  task automatic random_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    repeat (n) @(posedge clk);
  endtask

  // Send one beat; the prediction is queued at acceptance. busy is always high
  // in the cycle after an accept, so the idle cycle costs no throughput.
  task automatic send_item(logic [1:0] cmd, logic [62:0] a, logic [62:0] b,
                           logic [63:0] e);
    start        <= 1'b1;
    in_cmd       <= cmd;
    in_operand_a <= a;
    in_operand_b <= b;
    in_exponent  <= e;
    @(posedge clk);
    while (busy) @(posedge clk);
    value_q.push_back(predict_value(cmd, a, b, e));
    if (cmd == CMD_POW) n_pow++;
    n_sent++;
    start <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until nothing is outstanding, plus margin for a beat still in flight
  task automatic wait_drained();
    while (value_q.size() != 0 || busy) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_MODULUS: mod_n   = data[62:0];
      CFG_RBITS:   rbits_k = data[6:0];
      CFG_NINV:    ninv    = data;
      default:     r2_n    = data[62:0];
    endcase
    @(posedge clk);
  endtask

  // Derives n', R^2 mod n for an odd modulus and loads all four registers
  task automatic setup_modulus(logic [62:0] n);
    int           k;
    logic [63:0]  inv;
    logic [127:0] r1;
    logic [127:0] r2;
    k = 1;
    while (k < 63 && (n >> k) != 0) k++;
    k = k + 1;                               // one more than bit length
    inv = 64'd1;                             // Newton: inv = n^-1 mod 2^64
    repeat (7) inv = inv * (64'd2 - {1'b0, n} * inv);
    inv = -inv;
    if (k < 64) inv = inv & ((64'd1 << k) - 64'd1);
    r1 = (128'd1 << k) % {65'd0, n};         // R mod n
    r2 = (r1 * r1) % {65'd0, n};
    write_reg(CFG_MODULUS, {1'b0, n});
    write_reg(CFG_RBITS, 64'(k));
    write_reg(CFG_NINV, inv);
    write_reg(CFG_R2, r2[63:0]);
  endtask

  function automatic logic [62:0] rand63();
    return 63'({$urandom(), $urandom()});
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Operand below modulus most of the time, otherwise anything
  function automatic logic [62:0] rand_operand();
    if (mod_n > 1 && $urandom_range(0, 7) != 0) return rand63() % mod_n;
    return rand63();
  endfunction

  // Short exponents keep the power run time down; a few go full width
  function automatic logic [63:0] rand_exponent();
    case ($urandom_range(0, 9))
      0:       return 64'd0;
      1:       return rand64();
      2, 3:    return rand64() >> $urandom_range(32, 60);
      default: return rand64() >> $urandom_range(52, 63);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values of the registers with every command
  task automatic test_reset_config();
    send_item(CMD_MUL, 63'd0, 63'd0, 64'd0);
    send_item(CMD_TO, 63'd5, 63'd0, 64'd0);
    send_item(CMD_FROM, 63'd3, 63'd0, 64'd0);
    send_item(CMD_POW, 63'd2, 63'd0, 64'd7);
    wait_drained();
  endtask

  // Field extremes, zero exponent, unreduced operands, largest modulus
  task automatic test_directed();
    logic [62:0] top;
    top = '1;
    setup_modulus(63'd13);
    send_item(CMD_MUL, 63'd12, 63'd12, 64'd0);
    send_item(CMD_TO, 63'd1, top, 64'd0);
    send_item(CMD_FROM, 63'd12, 63'd0, 64'd0);
    send_item(CMD_POW, 63'd7, 63'd0, 64'd0);      // zero exponent
    send_item(CMD_POW, 63'd7, 63'd0, 64'd1);
    send_item(CMD_POW, 63'd0, 63'd0, 64'd5);
    send_item(CMD_MUL, top, top, 64'd0);          // unreduced operands
    send_item(CMD_POW, top, top, 64'd3);
    wait_drained();
    setup_modulus(top);                           // 63-bit modulus, k = 64
    send_item(CMD_MUL, top - 63'd1, top - 63'd1, '1);
    send_item(CMD_TO, top - 63'd1, 63'd0, 64'd0);
    send_item(CMD_FROM, top, 63'd0, 64'd0);
    send_item(CMD_POW, top - 63'd1, 63'd0, '1);   // all-ones exponent
    send_item(CMD_POW, 63'd2, 63'd0, 64'h8000_0000_0000_0000);
    send_item(CMD_MUL, 63'd0, top, 64'd0);
    wait_drained();
  endtask

  // Inconsistent settings and r_bits outside its range
  task automatic test_odd_config();
    write_reg(CFG_MODULUS, 64'd0);
    write_reg(CFG_RBITS, 64'd0);                  // saturates to 2
    write_reg(CFG_NINV, '1);
    write_reg(CFG_R2, '1);
    send_item(CMD_MUL, 63'd3, 63'd5, 64'd0);
    send_item(CMD_POW, 63'd3, 63'd0, 64'd9);
    wait_drained();
    write_reg(CFG_MODULUS, 64'd1000);             // even modulus
    write_reg(CFG_RBITS, 64'h7F);                 // saturates to WORD_BITS
    write_reg(CFG_NINV, rand64());
    send_item(CMD_TO, 63'd999, 63'd0, 64'd0);
    send_item(CMD_FROM, rand63(), 63'd0, 64'd0);
    send_item(CMD_POW, rand63(), 63'd0, 64'd21);
    wait_drained();
  endtask

  // Random phases over several moduli, each drained before reconfiguring
  task automatic test_random();
    logic [62:0] n;
    for (int phase = 0; phase < 12; phase++) begin
      if (phase == 11) begin
        for (int r = 0; r < 4; r++) write_reg(2'(r), rand64());  // noise config
      end else begin
        n = rand63() >> $urandom_range(0, 60);
        n[0] = 1'b1;
        if (n < 3) n = 63'd3;
        setup_modulus(n);
      end
      for (int i = 0; i < 100; i++) begin
        send_item(2'($urandom_range(0, 3)), rand_operand(), rand_operand(),
                  rand_exponent());
        if (phase % 3 != 0) random_gap();         // some phases run back to back
        if (i == 50 && phase == 4) wait_drained(); // sender holds off
      end
      wait_drained();
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_cmd       = CMD_MUL;
    in_operand_a = '0;
    in_operand_b = '0;
    in_exponent  = '0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_MODULUS;
    cfg_wdata    = '0;
    mod_n        = 63'd1;
    rbits_k      = 7'd2;
    ninv         = 64'd3;
    r2_n         = 63'd0;
    n_errors     = 0;
    n_sent       = 0;
    n_checked    = 0;
    n_pow        = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_config();
    test_directed();
    test_odd_config();
    test_random();
    wait_drained();

    $display("covered %0d beats (%0d powers), %0d results checked", n_sent, n_pow,
             n_checked);
    if (n_errors == 0 && value_q.size() == 0) begin
      $display("PASS montgomery_modular_exponentiation_unit");
    end else begin
      $display("%0d mismatches, %0d results missing", n_errors, value_q.size());
      $display("FAIL montgomery_modular_exponentiation_unit");
    end
    $finish;
  end

endmodule

### sim.f
sv/mmx_pkg.sv
sv/mmx_mont.sv
sv/mmx_dp.sv
sv/mmx_ctrl.sv
sv/montgomery_modular_exponentiation_unit.sv
sv/mmx_checker.sv
test/tb.sv
